@@ src/index_tracking_sorter_assert.svh @@
// Assertion macros for the sorter top level, compiled out for synthesis.
`ifndef INDEX_TRACKING_SORTER_ASSERT_SVH
`define INDEX_TRACKING_SORTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define ITS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ITS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ITS_ASSERT_NOW(lbl, ante, cons, msg)
`define ITS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ src/its_pkg.sv @@
// Shared constants and types for the index tracking sorter.
`default_nettype none

package its_pkg;

  localparam int MAX_LEN     = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int SRC_IDX_W   = 6;
  localparam int CNT_W       = $clog2(MAX_LEN + 1);
  localparam int OUT_DATA_W  = ((VALUE_WIDTH + SRC_IDX_W + 7) / 8) * 8;
  localparam int IN_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;

  typedef struct packed {
    logic                          vld;
    logic [SRC_IDX_W-1:0]          idx;
    logic signed [VALUE_WIDTH-1:0] val;
  } entry_t;

  typedef struct packed {
    logic ins;    // insert the broadcast word this cycle
    logic drain;  // shift every cell one place toward the head
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ src/its_cell.sv @@
// One sorter cell: holds a single entry, inserts in order and shifts on drain.
`default_nettype none

module its_cell (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire its_pkg::cell_ctl_t                    ctl,
  input  wire logic signed [its_pkg::VALUE_WIDTH-1:0] new_val,
  input  wire logic [its_pkg::SRC_IDX_W-1:0]         new_idx,
  input  wire logic                                  lt_prev,
  input  wire its_pkg::entry_t                       left_ent,
  input  wire its_pkg::entry_t                       right_ent,
  output logic                                       lt,
  output its_pkg::entry_t                            ent
);
  import its_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // An empty cell acts as plus infinity. Ties compare false, so an equal
  // newcomer lands behind older entries and arrival order is kept.
  assign lt  = !ent_r.vld || (new_val < ent_r.val);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.drain) begin
      ent_nxt = right_ent;
    end else if (ctl.ins) begin
      if (lt_prev) begin
        ent_nxt = left_ent;
      end else if (lt) begin
        ent_nxt.vld = 1'b1;
        ent_nxt.idx = new_idx;
        ent_nxt.val = new_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
    ent_r.idx <= ent_nxt.idx;
    ent_r.val <= ent_nxt.val;
  end

endmodule

`default_nettype wire

@@ src/index_tracking_sorter.sv @@
// Top level of the index tracking sorter: control and the chain of sorting cells.
`default_nettype none
`include "index_tracking_sorter_assert.svh"

// Stable ascending sorter for a streamed vector of signed Q1.31 words, built as
// a linear chain of MAX_LEN insertion cells. While loading, one word is taken
// every cycle: it is broadcast to all cells, each cell compares it against its
// own entry and the chain makes room as the word is stored, so the chain is always
// sorted with equal values in arrival order. Each stored word carries its
// arrival position as a tag. Words beyond MAX_LEN are dropped and the run is
// marked truncated. The word with tlast (stored too if there is room) closes
// the run: the input then stalls and the chain drains from its head, one result
// word per accepted output cycle. The head cell's register drives the output
// directly, and loading resumes in the cycle after the final result is taken.
module index_tracking_sorter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [its_pkg::IN_DATA_W-1:0]     in_tdata,   // [31:0] sample_value
  input  wire logic                              in_tlast,   // is_last
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [its_pkg::OUT_DATA_W-1:0]         out_tdata,  // sorted_value, source_index, pad
  output logic                                   out_tlast,  // end_of_run
  output logic                                   out_tuser   // truncated
);
  import its_pkg::*;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] remain_r;
  logic             ovf_r;

  logic             in_acc;
  logic             out_acc;
  logic             has_room;
  cell_ctl_t        ctl;
  logic signed [VALUE_WIDTH-1:0] new_val;
  logic [SRC_IDX_W-1:0]          new_idx;
  entry_t           empty_ent;

  entry_t           ents  [MAX_LEN];
  logic             lts   [MAX_LEN];

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_DRAIN);
  assign out_acc   = out_tvalid && out_tready;
  assign has_room  = (fill_r < CNT_W'(MAX_LEN));

  assign new_val   = in_tdata[VALUE_WIDTH-1:0];
  assign new_idx   = SRC_IDX_W'(fill_r);
  assign ctl.ins   = in_acc && has_room;
  assign ctl.drain = out_acc;
  assign empty_ent = '0;

  // Chain of cells: cell 0 is the head and always holds the smallest entry.
  for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_cell
    its_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_val   (new_val),
      .new_idx   (new_idx),
      .lt_prev   ((gi == 0) ? 1'b0 : lts[(gi == 0) ? 0 : gi - 1]),
      .left_ent  ((gi == 0) ? empty_ent : ents[(gi == 0) ? 0 : gi - 1]),
      .right_ent ((gi == MAX_LEN - 1) ? empty_ent : ents[(gi == MAX_LEN - 1) ? gi : gi + 1]),
      .lt        (lts[gi]),
      .ent       (ents[gi])
    );
  end

  // Result word straight from the head cell.
  always_comb begin
    out_tdata = '0;
    out_tdata[VALUE_WIDTH-1:0]                       = ents[0].val;
    out_tdata[VALUE_WIDTH+SRC_IDX_W-1:VALUE_WIDTH]   = ents[0].idx;
  end
  assign out_tlast = (remain_r == CNT_W'(1));
  assign out_tuser = ovf_r;

  // Run control: count stored words, note drops, then count down the drain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      fill_r   <= '0;
      remain_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (has_room) begin
              fill_r <= fill_r + CNT_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_tlast) begin
              state_r  <= ST_DRAIN;
              remain_r <= has_room ? fill_r + CNT_W'(1) : fill_r;
            end
          end
        end
        ST_DRAIN: begin
          if (out_acc) begin
            remain_r <= remain_r - CNT_W'(1);
            if (remain_r == CNT_W'(1)) begin
              state_r <= ST_LOAD;
              fill_r  <= '0;
              ovf_r   <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  `ITS_ASSERT_NOW(a_drain_has_words, out_tvalid, remain_r != '0, "drain with zero words left")
  `ITS_ASSERT_NOW(a_head_valid, out_tvalid, ents[0].vld, "result taken from an empty head cell")
  `ITS_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CNT_W'(MAX_LEN), "fill count beyond capacity")
  `ITS_ASSERT_NEXT(a_run_closes, out_acc && out_tlast, in_tready && !ents[0].vld,
                   "chain not empty after the final result")
  `ITS_ASSERT_NEXT(a_last_starts_drain, in_acc && in_tlast, out_tvalid,
                   "closing word did not start the drain")

endmodule

`default_nettype wire
